// File: hw/rtl/bra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types and constants for the bitmap run allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_TEST  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_SCAN  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_TEST  = 2'd1,
        S_WRITE = 2'd2,
        S_SCAN  = 2'd3
    } t_state;

    // addressable resources are limited by the 10-bit index
    localparam int unsigned INDEX_BYTES = 128;
    localparam logic [7:0]  MAP_BYTES_RESET = 8'd128;
    localparam logic [0:0]  REG_MAP_BYTES = 1'b0;

endpackage

// File: hw/rtl/bitmap_run_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_run_allocator_unit
// Bit-per-resource usage map in a byte-wide memory with first-fit search
// for a run of free resources.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+-----------------------------
//  request  | in        | start, busy (beat: start&!busy)| i_mode, i_bit_index,
//           |           |                               | i_bit_value, i_run_length
//  result   | out       | o_done, one cycle, no stall   | o_found, o_run_start,
//           |           |                               | o_tested_bit
//  config   | in/out    | apb (psel penable pwrite ...)  | map_bytes at address 0
//
//  clear all: result in the cycle after the beat, busy never rises
//  test / write: one memory read (plus write-back), result registered after S_TEST/S_WRITE;
//  an index outside the map answers in the cycle after the beat, like clear all
//  scan: one map byte per cycle through the memory read port; at most
//  min(map_bytes, depth) bytes, result in the cycle after the hit or last byte
//  reset clears the per-entry valid bits at once, so no clearing pass
//  results cannot be stalled; each is shown for exactly one cycle
// ----------------------------------------------------------------------------
module bitmap_run_allocator_unit #(
    parameter int unsigned MAP_BYTES_MAX = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [9:0]  i_bit_index,
    input  logic        i_bit_value,
    input  logic [10:0] i_run_length,
    output logic        o_done,
    output logic        o_found,
    output logic [9:0]  o_run_start,
    output logic        o_tested_bit,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned DEPTH = (MAP_BYTES_MAX < bra_pkg::INDEX_BYTES) ?
                                    MAP_BYTES_MAX : bra_pkg::INDEX_BYTES;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // byte memory with one valid bit per entry
    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [7:0]       r_rd_q;
    logic             r_rd_valid;

    bra_pkg::t_state r_state, n_state;
    logic [7:0]      r_map_bytes;
    logic [AW-1:0]   r_addr, n_addr;
    logic [2:0]      r_pos, n_pos;
    logic            r_val, n_val;
    logic [10:0]     r_want, n_want;
    logic [10:0]     r_run, n_run;
    logic            r_done, n_done;
    logic            r_found, n_found;
    logic [9:0]      r_start, n_start;
    logic            r_tested, n_tested;

    logic            accept;
    logic            cfg_wr;
    logic [7:0]      eff_bytes;
    logic [10:0]     active_bits;
    logic            idx_in_range;
    logic [7:0]      byte_q;
    logic [7:0]      wr_byte;
    logic            mem_we;
    logic            clear_all;
    logic            last_byte;
    logic            hit;
    logic [2:0]      hit_k;
    logic [10:0]     scan_run;
    logic [10:0]     hit_start;

    assign accept  = start && !busy;
    assign busy    = (r_state != bra_pkg::S_IDLE);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == bra_pkg::REG_MAP_BYTES);
    assign prdata  = (paddr[2] == bra_pkg::REG_MAP_BYTES) ? {24'd0, r_map_bytes} : 32'd0;

    assign o_done       = r_done;
    assign o_found      = r_found;
    assign o_run_start  = r_start;
    assign o_tested_bit = r_tested;

    assign eff_bytes    = (r_map_bytes > 8'(DEPTH)) ? 8'(DEPTH) : r_map_bytes;
    assign active_bits  = {eff_bytes, 3'b000};
    assign idx_in_range = ({1'b0, i_bit_index[9:3]} < eff_bytes);
    assign byte_q       = r_rd_valid ? r_rd_q : 8'h00;
    assign last_byte    = ((8'(r_addr) + 8'd1) == eff_bytes);

    // write-back byte for a single bit update
    always_comb begin
        wr_byte        = byte_q;
        wr_byte[r_pos] = r_val;
    end

    // run counter over the eight bits of the current byte
    always_comb begin
        scan_run = r_run;
        hit      = 1'b0;
        hit_k    = 3'd0;
        for (int k = 0; k < 8; k++) begin
            if (!hit) begin
                if (byte_q[k]) begin
                    scan_run = 11'd0;
                end else begin
                    scan_run = scan_run + 11'd1;
                end
                if (scan_run == r_want) begin
                    hit   = 1'b1;
                    hit_k = 3'(k);
                end
            end
        end
        hit_start = 11'({r_addr, hit_k}) + 11'd1 - r_want;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_bytes <= bra_pkg::MAP_BYTES_RESET;
        end else if (cfg_wr) begin
            r_map_bytes <= pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bra_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_want   <= n_want;
        r_run    <= n_run;
        r_found  <= n_found;
        r_start  <= n_start;
        r_tested <= n_tested;
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_pos     = r_pos;
        n_val     = r_val;
        n_want    = r_want;
        n_run     = r_run;
        n_done    = 1'b0;
        n_found   = 1'b0;
        n_start   = 10'd0;
        n_tested  = 1'b0;
        mem_we    = 1'b0;
        clear_all = 1'b0;
        unique case (r_state)
            bra_pkg::S_IDLE: begin
                if (accept) begin
                    n_pos  = i_bit_index[2:0];
                    n_val  = i_bit_value;
                    n_want = (i_run_length == 11'd0) ? 11'd1 : i_run_length;
                    n_run  = 11'd0;
                    unique case (bra_pkg::t_mode'(i_mode)) inside
                        bra_pkg::MODE_CLEAR: begin
                            clear_all = 1'b1;
                            n_done    = 1'b1;
                        end
                        bra_pkg::MODE_TEST, bra_pkg::MODE_WRITE: begin
                            n_addr = AW'(i_bit_index[9:3]);
                            if (idx_in_range) begin
                                n_state = (bra_pkg::t_mode'(i_mode) == bra_pkg::MODE_TEST) ?
                                          bra_pkg::S_TEST : bra_pkg::S_WRITE;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        bra_pkg::MODE_SCAN: begin
                            n_addr = '0;
                            if (eff_bytes == 8'd0) begin
                                n_done = 1'b1;
                            end else begin
                                n_state = bra_pkg::S_SCAN;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            bra_pkg::S_TEST: begin
                n_done   = 1'b1;
                n_tested = byte_q[r_pos];
                n_state  = bra_pkg::S_IDLE;
            end
            bra_pkg::S_WRITE: begin
                mem_we  = 1'b1;
                n_done  = 1'b1;
                n_state = bra_pkg::S_IDLE;
            end
            bra_pkg::S_SCAN: begin
                n_run = scan_run;
                if (hit) begin
                    n_done  = 1'b1;
                    n_found = 1'b1;
                    n_start = hit_start[9:0];
                    n_state = bra_pkg::S_IDLE;
                end else if (last_byte) begin
                    n_done  = 1'b1;
                    n_state = bra_pkg::S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            default: begin
                n_state = bra_pkg::S_IDLE;
            end
        endcase
    end

    // memory: one read and one write port, read data registered
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= wr_byte;
        end
        r_rd_q <= mem[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[n_addr] && !(mem_we && (n_addr == r_addr)) && !clear_all;
            if (clear_all) begin
                r_valid <= '0;
            end else if (mem_we) begin
                r_valid[r_addr] <= 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_mode == bra_pkg::MODE_CLEAR) |=> o_done && !o_found && !busy)
        else $error("clear-all did not complete in one cycle");

    a_scan_addr_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bra_pkg::S_SCAN) |-> (8'(r_addr) < eff_bytes))
        else $error("scan address beyond map");

    a_found_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_found |-> ({1'b0, o_run_start} < active_bits))
        else $error("run start outside active map");

    a_result_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_found && o_tested_bit))
        else $error("scan and test result mixed");

    a_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy) || $past(start))
        else $error("result without a request");
`endif

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmap run allocator: requests are driven over
// the start/busy handshake, clears and writes update a private copy of the
// usage map, and each o_done beat is compared against the oldest prediction.
// The map length register is swept over its extremes through the apb port.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned CHUNK_ITEMS = 175;

    typedef struct packed {
        logic       found;
        logic [9:0] run_start;
        logic       tested;
    } t_alloc_result;

    class alloc_scoreboard;
        bit [7:0]      usage [bra_pkg::INDEX_BYTES];
        bit [7:0]      map_bytes;
        t_alloc_result pending [$];
        int            fails;

        function new();
            foreach (usage[i]) usage[i] = '0;
            map_bytes = bra_pkg::MAP_BYTES_RESET;
            fails = 0;
        endfunction

        // bits that can be addressed and searched with the current length
        function int unsigned live_bits();
            int unsigned nb;
            nb = (map_bytes > bra_pkg::INDEX_BYTES) ? bra_pkg::INDEX_BYTES : map_bytes;
            nb = nb * 8;
            return (nb > 1024) ? 1024 : nb;
        endfunction

        function bit bit_at(int unsigned n);
            if (n >= live_bits()) return 1'b0;
            return usage[n >> 3][n & 7];
        endfunction

        function void note_request(bra_pkg::t_mode mode, logic [9:0] idx, logic val,
                                   logic [10:0] len);
            t_alloc_result r;
            int unsigned   want;
            int unsigned   run;
            int unsigned   nbits;
            r = '0;
            case (mode)
                bra_pkg::MODE_CLEAR: begin
                    foreach (usage[i]) usage[i] = '0;
                end
                bra_pkg::MODE_TEST: begin
                    r.tested = bit_at(idx);
                end
                bra_pkg::MODE_WRITE: begin
                    if (idx < live_bits()) usage[idx >> 3][idx[2:0]] = val;
                end
                default: begin
                    want = (len == 0) ? 1 : len;
                    run = 0;
                    nbits = live_bits();
                    for (int unsigned i = 0; i < nbits; i++) begin
                        if (bit_at(i)) run = 0;
                        else run++;
                        if (run == want) begin
                            r.found = 1'b1;
                            r.run_start = 10'(i + 1 - want);
                            break;
                        end
                    end
                end
            endcase
            pending.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            fails++;
        endtask

        task check_result(logic found, logic [9:0] run_start, logic tested);
            t_alloc_result e;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%b start=%0d tested=%b",
                                          found, run_start, tested));
                return;
            end
            e = pending.pop_front();
            if (found !== e.found)
                report_mismatch($sformatf("found %b, expected %b", found, e.found));
            if (run_start !== e.run_start)
                report_mismatch($sformatf("run_start %0d, expected %0d",
                                          run_start, e.run_start));
            if (tested !== e.tested)
                report_mismatch($sformatf("tested_bit %b, expected %b", tested, e.tested));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_mode = '0;
    logic [9:0]  i_bit_index = '0;
    logic        i_bit_value = 1'b0;
    logic [10:0] i_run_length = '0;
    logic        o_done;
    logic        o_found;
    logic [9:0]  o_run_start;
    logic        o_tested_bit;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    alloc_scoreboard sb = new();
    int unsigned     cycles = 0;
    int unsigned     idle_pct = 0;

    bitmap_run_allocator_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_bit_index  (i_bit_index),
        .i_bit_value  (i_bit_value),
        .i_run_length (i_run_length),
        .o_done       (o_done),
        .o_found      (o_found),
        .o_run_start  (o_run_start),
        .o_tested_bit (o_tested_bit),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // request beats feed the predictor, result beats are checked in order
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) sb.check_result(o_found, o_run_start, o_tested_bit);
            if (start && !busy)
                sb.note_request(bra_pkg::t_mode'(i_mode), i_bit_index, i_bit_value,
                                i_run_length);
        end
    end

    task send_item(bra_pkg::t_mode m, logic [9:0] idx, logic val, logic [10:0] len);
        i_mode <= m;
        i_bit_index <= idx;
        i_bit_value <= val;
        i_run_length <= len;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // stop requesting and let every outstanding result come back
    task drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task set_map_bytes(logic [7:0] val);
        logic [31:0] rd;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * bra_pkg::REG_MAP_BYTES);
        pwdata <= {24'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.map_bytes = val;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        // read back through the same port
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (rd !== {24'd0, val})
            sb.report_mismatch($sformatf("map_bytes read %0h, expected %0h", rd, val));
    endtask

    function logic [9:0] pick_index(int unsigned nbits);
        if (nbits == 0 || $urandom_range(99) < 12) return 10'($urandom);
        return 10'($urandom_range(nbits - 1));
    endfunction

    task run_random(int unsigned n, int unsigned pct_set);
        int unsigned sent;
        int unsigned nbits;
        int unsigned pick;
        int unsigned len;
        logic [9:0]  base;
        logic [10:0] want;
        logic        v;
        sent = 0;
        while (sent < n) begin
            nbits = sb.live_bits();
            pick = $urandom_range(99);
            if (pick < 2) begin
                send_item(bra_pkg::MODE_CLEAR, 10'($urandom), 1'($urandom), 11'($urandom));
                sent++;
            end else if (pick < 14) begin
                // allocate or release a contiguous block, as a kernel would
                len = $urandom_range(1, 16);
                base = pick_index(nbits);
                v = ($urandom_range(99) < pct_set);
                for (int unsigned k = 0; k < len && sent < n; k++) begin
                    send_item(bra_pkg::MODE_WRITE, 10'(base + k), v, 11'($urandom));
                    sent++;
                end
            end else if (pick < 36) begin
                send_item(bra_pkg::MODE_TEST, pick_index(nbits), 1'($urandom),
                          11'($urandom));
                sent++;
            end else if (pick < 64) begin
                send_item(bra_pkg::MODE_WRITE, pick_index(nbits),
                          ($urandom_range(99) < pct_set), 11'($urandom));
                sent++;
            end else begin
                pick = $urandom_range(99);
                if (pick < 55) want = 11'($urandom_range(1, 8));
                else if (pick < 80) want = 11'($urandom_range(1, nbits / 4 + 1));
                else if (pick < 90) want = 11'($urandom);
                else begin
                    case ($urandom_range(3))
                        0: want = '0;
                        1: want = 11'(nbits);
                        2: want = 11'(nbits + 1);
                        default: want = 11'(nbits - 1);
                    endcase
                end
                send_item(bra_pkg::MODE_SCAN, 10'($urandom), 1'($urandom), want);
                sent++;
            end
        end
    endtask

    logic [7:0] chunk_len [8] = '{8'd16, 8'd128, 8'd255, 8'd1, 8'd0, 8'd3, 8'd64, 8'd200};

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full map straight out of reset
        send_item(bra_pkg::MODE_SCAN, '0, 1'b0, 11'd0);
        send_item(bra_pkg::MODE_SCAN, '0, 1'b0, 11'd1024);
        send_item(bra_pkg::MODE_SCAN, '0, 1'b0, 11'd1025);
        send_item(bra_pkg::MODE_SCAN, 10'h3ff, 1'b1, 11'h7ff);
        send_item(bra_pkg::MODE_WRITE, 10'd0, 1'b1, 11'h7ff);
        send_item(bra_pkg::MODE_WRITE, 10'h3ff, 1'b1, '0);
        send_item(bra_pkg::MODE_TEST, 10'd0, 1'b0, '0);
        send_item(bra_pkg::MODE_TEST, 10'h3ff, 1'b0, '0);
        send_item(bra_pkg::MODE_TEST, 10'd512, 1'b1, '0);
        send_item(bra_pkg::MODE_SCAN, '0, 1'b0, 11'd1);
        send_item(bra_pkg::MODE_SCAN, '0, 1'b0, 11'd1022);
        send_item(bra_pkg::MODE_SCAN, '0, 1'b0, 11'd1023);
        send_item(bra_pkg::MODE_WRITE, 10'd0, 1'b0, '0);
        send_item(bra_pkg::MODE_SCAN, '0, 1'b0, 11'd1023);
        send_item(bra_pkg::MODE_WRITE, 10'd1000, 1'b1, '0);
        drain();

        // two-byte map: writes past the end are dropped, clear reaches beyond
        set_map_bytes(8'd2);
        send_item(bra_pkg::MODE_WRITE, 10'd16, 1'b1, '0);
        send_item(bra_pkg::MODE_TEST, 10'd16, 1'b0, '0);
        send_item(bra_pkg::MODE_TEST, 10'd1000, 1'b0, '0);
        send_item(bra_pkg::MODE_WRITE, 10'd15, 1'b1, '0);
        send_item(bra_pkg::MODE_SCAN, '0, 1'b0, 11'd15);
        send_item(bra_pkg::MODE_SCAN, '0, 1'b0, 11'd16);
        send_item(bra_pkg::MODE_WRITE, 10'd5, 1'b1, '0);
        send_item(bra_pkg::MODE_SCAN, '0, 1'b0, 11'd10);
        send_item(bra_pkg::MODE_SCAN, '0, 1'b0, 11'd9);
        send_item(bra_pkg::MODE_CLEAR, 10'h3ff, 1'b1, 11'h7ff);
        drain();

        set_map_bytes(8'd0);
        send_item(bra_pkg::MODE_WRITE, 10'd0, 1'b1, '0);
        send_item(bra_pkg::MODE_TEST, 10'd0, 1'b0, '0);
        send_item(bra_pkg::MODE_SCAN, '0, 1'b0, 11'd1);
        drain();

        set_map_bytes(8'd128);
        send_item(bra_pkg::MODE_TEST, 10'd1000, 1'b0, '0);
        send_item(bra_pkg::MODE_TEST, 10'h3ff, 1'b0, '0);

        for (int c = 0; c < 8; c++) begin
            drain();
            set_map_bytes(chunk_len[c]);
            idle_pct = (c < 3) ? 37 : (c < 6) ? 88 : 0;
            run_random(CHUNK_ITEMS, $urandom_range(35, 70));
        end

        drain();
        repeat (150) @(posedge i_clk);
        if (sb.fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
